FILE: hw/rtl/scpd_pkg.sv
// ----------------------------------------------------------------------------
// scpd_pkg
// Types and constants shared by the sync / length / CRC-16 packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package scpd_pkg;

	// CRC-16/CCITT-FALSE: poly 0x1021, init 0xFFFF, no reflection, no final xor.
	localparam int unsigned CRC_W = 16;
	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

	// Field widths.
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned PLEN_W = 7;
	localparam int unsigned ADDR_W = 6;

	// Register reset values.
	localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'hAA;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'h55;

	// Register indexes on the configuration port.
	localparam logic [0:0] REG_SYNC_FIRST  = 1'b0;
	localparam logic [0:0] REG_SYNC_SECOND = 1'b1;

	// Input item codes.
	localparam logic FUNC_BYTE   = 1'b0;
	localparam logic FUNC_RESYNC = 1'b1;

	// Frame phase while parsing the byte stream.
	typedef enum logic [3:0] {
		PH_SYNC1 = 4'd0,
		PH_SYNC2 = 4'd1,
		PH_CMD   = 4'd2,
		PH_SEQ   = 4'd3,
		PH_LENH  = 4'd4,
		PH_LENL  = 4'd5,
		PH_DATA  = 4'd6,
		PH_CRCH  = 4'd7,
		PH_CRCL  = 4'd8
	} phase_t;

	// Intake / readout sequencer state.
	typedef enum logic [1:0] {
		CT_IDLE,
		CT_READ,
		CT_LOAD
	} ctrl_t;

	// Commands to the shared CRC unit.
	typedef struct packed {
		logic              init;
		logic              start;
		logic [BYTE_W-1:0] data;
	} crc_cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/scpd_if.sv
// ----------------------------------------------------------------------------
// scpd_if
// Valid/ready channels of the packet deframer: received bytes and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface scpd_byte_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] data_byte;

	modport source (output valid, output func, output data_byte, input ready);
	modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface scpd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] command;
	logic [7:0] sequence_res;
	logic [6:0] payload_length;
	logic       has_payload;
	logic [5:0] byte_index;
	logic [7:0] payload_byte;
	logic       last;

	modport source (
		output valid, output command, output sequence_res, output payload_length,
		output has_payload, output byte_index, output payload_byte, output last,
		input ready
	);
	modport sink (
		input valid, input command, input sequence_res, input payload_length,
		input has_payload, input byte_index, input payload_byte, input last,
		output ready
	);
endinterface

`default_nettype wire

FILE: hw/rtl/scpd_crc_unit.sv
// ----------------------------------------------------------------------------
// scpd_crc_unit
// Shared CRC-16 step unit: folds one byte in as two nibble steps, the high
// nibble in the start cycle and the low nibble after it.
// ----------------------------------------------------------------------------
`default_nettype none

module scpd_crc_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire scpd_pkg::crc_cmd_t             cmd,
	output logic                                busy,
	output logic [scpd_pkg::CRC_W-1:0]          crc
);

	logic [scpd_pkg::CRC_W-1:0] crc_q;
	logic [scpd_pkg::CRC_W-1:0] crc_next;
	logic [3:0]                 nib_q;
	logic [3:0]                 nib_in;
	logic                       busy_q;

	// Four MSB-first bit steps of the CRC shift register.
	function automatic logic [scpd_pkg::CRC_W-1:0] crc_step4(
		input logic [scpd_pkg::CRC_W-1:0] c,
		input logic [3:0]                 n
	);
		logic [scpd_pkg::CRC_W-1:0] r;
		logic                       fb;
		r = c;
		for (int i = 3; i >= 0; i--) begin
			fb = r[scpd_pkg::CRC_W-1] ^ n[i];
			r  = {r[scpd_pkg::CRC_W-2:0], 1'b0} ^ (fb ? scpd_pkg::CRC_POLY : '0);
		end
		return r;
	endfunction

	// One step instance, fed by the new high nibble or the held low nibble.
	always_comb begin
		nib_in   = cmd.start ? cmd.data[7:4] : nib_q;
		crc_next = crc_step4(crc_q, nib_in);
	end

	// CRC register and step sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= scpd_pkg::CRC_INIT;
			nib_q  <= '0;
			busy_q <= 1'b0;
		end else if (cmd.init) begin
			crc_q  <= scpd_pkg::CRC_INIT;
			busy_q <= 1'b0;
		end else if (cmd.start) begin
			crc_q  <= crc_next;
			nib_q  <= cmd.data[3:0];
			busy_q <= 1'b1;
		end else if (busy_q) begin
			crc_q  <= crc_next;
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;
	assign crc  = crc_q;

endmodule

`default_nettype wire

FILE: hw/rtl/scpd_payload_ram.sv
// ----------------------------------------------------------------------------
// scpd_payload_ram
// Payload store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scpd_payload_ram #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                              clk,
	input  wire logic                              we,
	input  wire logic [scpd_pkg::ADDR_W-1:0]       waddr,
	input  wire logic [scpd_pkg::BYTE_W-1:0]       wdata,
	input  wire logic                              re,
	input  wire logic [scpd_pkg::ADDR_W-1:0]       raddr,
	output logic      [scpd_pkg::BYTE_W-1:0]       rdata
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [scpd_pkg::BYTE_W-1:0] mem_q [DEPTH];
	logic [scpd_pkg::BYTE_W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr[AW-1:0]] <= wdata;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr[AW-1:0]];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/sync_crc16_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// sync_crc16_packet_deframer_top
// Sync hunt, header and payload capture with CRC-16/CCITT-FALSE check;
// a good packet is played out as one result per payload byte (one for an empty packet).
// ----------------------------------------------------------------------------
//  Channel     Dir   Handshake     Payload
//  byte_ch     in    valid/ready   func, data_byte
//  result_ch   out   valid/ready   command, sequence_res, payload_length,
//                                  has_payload, byte_index, payload_byte, last
//  cfg_*       in    write enable  cfg_index, cfg_data (sync_first, sync_second)
//
//  A byte covered by the CRC keeps intake closed while the shared nibble-wide
//  CRC unit makes its second pass; sync, CRC and resync items do not.
//  After a matching CRC low byte, each result takes a payload RAM read, then an
//  output register load plus any result-side stall (an empty packet skips the
//  read); intake stays closed until the last result is loaded.
//  Reset clears the control state and sync registers only; the payload RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_crc16_packet_deframer_top #(
	parameter int unsigned MAX_PAYLOAD = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [0:0]                    cfg_index,
	input  wire logic [scpd_pkg::BYTE_W-1:0]   cfg_data,
	scpd_byte_if.sink                          byte_ch,
	scpd_result_if.source                      result_ch
);

	localparam logic [scpd_pkg::LEN_W-1:0] MAX_LEN = scpd_pkg::LEN_W'(MAX_PAYLOAD);

	// Configuration registers.
	logic [scpd_pkg::BYTE_W-1:0] sync_first_q;
	logic [scpd_pkg::BYTE_W-1:0] sync_second_q;

	// Control state.
	scpd_pkg::phase_t phase_q, phase_d;
	scpd_pkg::ctrl_t  ctrl_q, ctrl_d;
	logic             out_valid_q;

	// Frame capture registers.
	logic [scpd_pkg::BYTE_W-1:0] held_cmd_q;
	logic [scpd_pkg::BYTE_W-1:0] held_seq_q;
	logic [scpd_pkg::BYTE_W-1:0] len_high_q;
	logic [scpd_pkg::PLEN_W-1:0] held_len_q;
	logic [scpd_pkg::PLEN_W-1:0] count_q;
	logic [scpd_pkg::BYTE_W-1:0] crc_high_q;
	logic [scpd_pkg::ADDR_W-1:0] idx_q;

	// Output register.
	logic [scpd_pkg::BYTE_W-1:0] out_cmd_q;
	logic [scpd_pkg::BYTE_W-1:0] out_seq_q;
	logic [scpd_pkg::PLEN_W-1:0] out_len_q;
	logic                        out_has_q;
	logic [scpd_pkg::ADDR_W-1:0] out_idx_q;
	logic [scpd_pkg::BYTE_W-1:0] out_byte_q;
	logic                        out_last_q;

	// Decoded control.
	logic                        accept;
	logic [scpd_pkg::BYTE_W-1:0] rx_byte;
	logic [scpd_pkg::LEN_W-1:0]  len_full;
	logic [scpd_pkg::PLEN_W-1:0] count_inc;
	logic                        out_free;
	logic                        last_now;
	logic                        has_now;
	scpd_pkg::crc_cmd_t          crc_cmd;
	logic                        crc_busy;
	logic [scpd_pkg::CRC_W-1:0]  crc_value;
	logic                        ram_we;
	logic                        ram_re;
	logic [scpd_pkg::BYTE_W-1:0] ram_rdata;
	logic                        out_load;
	logic                        cap_cmd;
	logic                        cap_seq;
	logic                        cap_lenh;
	logic                        cap_lenl;
	logic                        cap_crch;
	logic                        cnt_inc;
	logic                        idx_clr;
	logic                        idx_inc;

	// Shared CRC unit.
	scpd_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (crc_cmd),
		.busy   (crc_busy),
		.crc    (crc_value)
	);

	// Payload store.
	scpd_payload_ram #(
		.DEPTH (MAX_PAYLOAD)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[scpd_pkg::ADDR_W-1:0]),
		.wdata (rx_byte),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// Handshake and shared decode.
	assign byte_ch.ready = (ctrl_q == scpd_pkg::CT_IDLE) && !crc_busy;
	assign accept        = byte_ch.valid && byte_ch.ready;
	assign rx_byte       = byte_ch.data_byte;
	assign len_full      = {len_high_q, rx_byte};
	assign count_inc     = count_q + scpd_pkg::PLEN_W'(1);
	assign out_free      = !out_valid_q || result_ch.ready;
	assign has_now       = (held_len_q != '0);
	assign last_now      = !has_now ||
	                       ({1'b0, idx_q} + scpd_pkg::PLEN_W'(1) == held_len_q);

	// Next state for frame phase and sequencer, plus datapath strobes.
	always_comb begin
		phase_d  = phase_q;
		ctrl_d   = ctrl_q;
		crc_cmd  = '0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		out_load = 1'b0;
		cap_cmd  = 1'b0;
		cap_seq  = 1'b0;
		cap_lenh = 1'b0;
		cap_lenl = 1'b0;
		cap_crch = 1'b0;
		cnt_inc  = 1'b0;
		idx_clr  = 1'b0;
		idx_inc  = 1'b0;
		crc_cmd.data = rx_byte;

		// Intake of one byte or a resync.
		if (accept) begin
			if (byte_ch.func == scpd_pkg::FUNC_RESYNC) begin
				phase_d      = scpd_pkg::PH_SYNC1;
				crc_cmd.init = 1'b1;
			end else begin
				unique case (phase_q)
					scpd_pkg::PH_SYNC1: begin
						if (rx_byte == sync_first_q) begin
							phase_d = scpd_pkg::PH_SYNC2;
						end
					end
					scpd_pkg::PH_SYNC2: begin
						// The second-sync match wins when both registers agree.
						if (rx_byte == sync_second_q) begin
							phase_d      = scpd_pkg::PH_CMD;
							crc_cmd.init = 1'b1;
						end else if (rx_byte != sync_first_q) begin
							phase_d = scpd_pkg::PH_SYNC1;
						end
					end
					scpd_pkg::PH_CMD: begin
						cap_cmd       = 1'b1;
						crc_cmd.start = 1'b1;
						phase_d       = scpd_pkg::PH_SEQ;
					end
					scpd_pkg::PH_SEQ: begin
						cap_seq       = 1'b1;
						crc_cmd.start = 1'b1;
						phase_d       = scpd_pkg::PH_LENH;
					end
					scpd_pkg::PH_LENH: begin
						cap_lenh      = 1'b1;
						crc_cmd.start = 1'b1;
						phase_d       = scpd_pkg::PH_LENL;
					end
					scpd_pkg::PH_LENL: begin
						cap_lenl      = 1'b1;
						crc_cmd.start = 1'b1;
						if (len_full > MAX_LEN) begin
							phase_d = scpd_pkg::PH_SYNC1;
						end else if (len_full == '0) begin
							phase_d = scpd_pkg::PH_CRCH;
						end else begin
							phase_d = scpd_pkg::PH_DATA;
						end
					end
					scpd_pkg::PH_DATA: begin
						ram_we        = 1'b1;
						crc_cmd.start = 1'b1;
						cnt_inc       = 1'b1;
						if (count_inc >= held_len_q) begin
							phase_d = scpd_pkg::PH_CRCH;
						end
					end
					scpd_pkg::PH_CRCH: begin
						cap_crch = 1'b1;
						phase_d  = scpd_pkg::PH_CRCL;
					end
					scpd_pkg::PH_CRCL: begin
						phase_d = scpd_pkg::PH_SYNC1;
						if ({crc_high_q, rx_byte} == crc_value) begin
							idx_clr = 1'b1;
							ctrl_d  = has_now ? scpd_pkg::CT_READ : scpd_pkg::CT_LOAD;
						end
					end
					default: begin
						phase_d = scpd_pkg::PH_SYNC1;
					end
				endcase
			end
		end

		// Readout of a good packet, one result per pass.
		unique case (ctrl_q)
			scpd_pkg::CT_IDLE: begin
			end
			scpd_pkg::CT_READ: begin
				ram_re = 1'b1;
				ctrl_d = scpd_pkg::CT_LOAD;
			end
			scpd_pkg::CT_LOAD: begin
				if (out_free) begin
					out_load = 1'b1;
					if (last_now) begin
						ctrl_d = scpd_pkg::CT_IDLE;
					end else begin
						idx_inc = 1'b1;
						ctrl_d  = scpd_pkg::CT_READ;
					end
				end
			end
			default: begin
				ctrl_d = scpd_pkg::CT_IDLE;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= scpd_pkg::SYNC_FIRST_RESET;
			sync_second_q <= scpd_pkg::SYNC_SECOND_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				scpd_pkg::REG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				scpd_pkg::REG_SYNC_SECOND: sync_second_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Control state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= scpd_pkg::PH_SYNC1;
			ctrl_q      <= scpd_pkg::CT_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			ctrl_q  <= ctrl_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Frame capture and readout index.
	always_ff @(posedge clk) begin
		if (cap_cmd) begin
			held_cmd_q <= rx_byte;
		end
		if (cap_seq) begin
			held_seq_q <= rx_byte;
		end
		if (cap_lenh) begin
			len_high_q <= rx_byte;
		end
		if (cap_lenl) begin
			held_len_q <= len_full[scpd_pkg::PLEN_W-1:0];
			count_q    <= '0;
		end else if (cnt_inc) begin
			count_q <= count_inc;
		end
		if (cap_crch) begin
			crc_high_q <= rx_byte;
		end
		if (idx_clr) begin
			idx_q <= '0;
		end else if (idx_inc) begin
			idx_q <= idx_q + scpd_pkg::ADDR_W'(1);
		end
	end

	// Output register; an empty packet carries zero byte fields.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_cmd_q  <= held_cmd_q;
			out_seq_q  <= held_seq_q;
			out_len_q  <= held_len_q;
			out_has_q  <= has_now;
			out_idx_q  <= has_now ? idx_q : '0;
			out_byte_q <= has_now ? ram_rdata : '0;
			out_last_q <= last_now;
		end
	end

	assign result_ch.valid          = out_valid_q;
	assign result_ch.command        = out_cmd_q;
	assign result_ch.sequence_res   = out_seq_q;
	assign result_ch.payload_length = out_len_q;
	assign result_ch.has_payload    = out_has_q;
	assign result_ch.byte_index     = out_idx_q;
	assign result_ch.payload_byte   = out_byte_q;
	assign result_ch.last           = out_last_q;

endmodule

`default_nettype wire
